### hw/rtl/pal_pkg.sv
// package for the positional array list block
// holds field widths, operation and status codes, and controller/datapath structs
// no dependencies
package pal_pkg;

  localparam int ModeW     = 3;
  localparam int DataW     = 32;
  localparam int LocW      = 4;
  localparam int StatW     = 2;
  localparam int PosW      = 4;
  localparam int LenW      = 4;
  localparam int CapDefault = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 3'd0,
    MODE_FRONT  = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_LENGTH = 3'd4,
    MODE_LIST   = 3'd5
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADLOC = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic op_en;
    logic list_en;
  } pal_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic list_req;
    logic out_free;
    logic list_last;
  } pal_sts_t;

endpackage

### hw/rtl/pal_ctrl.sv
// controller for the positional array list block
// sequences single-beat operations and multi-beat listing
// depends on pal_pkg
module pal_ctrl
  import pal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pal_sts_t sts_i,
  output pal_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    cmd_o.op_en   = 1'b0;
    cmd_o.list_en = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o  = !sts_i.out_free;
        cmd_o.op_en = in_valid_i && sts_i.out_free;
        if (cmd_o.op_en && sts_i.list_req) begin
          state_d = S_LIST;
        end
      end
      S_LIST: begin
        cmd_o.list_en = sts_i.out_free;
        if (sts_i.out_free && sts_i.list_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/pal_dp.sv
// datapath for the positional array list block
// entry cells with parallel shift, entry count, list index and result register
// depends on pal_pkg
module pal_dp
  import pal_pkg::*;
#(
  parameter int Capacity = CapDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pal_cmd_t                cmd_i,
  output pal_sts_t                sts_o,
  input  logic [ModeW-1:0]        mode_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [LocW-1:0]         location_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic signed [DataW-1:0] data_out_o,
  output logic [PosW-1:0]         position_o,
  output logic [LenW-1:0]         length_o,
  output logic                    last_o
);

  localparam int CntW = $clog2(Capacity + 1);
  localparam int IdxW = $clog2(Capacity);
  localparam int CmpW = (LocW > CntW) ? LocW : CntW;

  logic signed [DataW-1:0] cells_q [Capacity];
  logic signed [DataW-1:0] cells_d [Capacity];
  logic [CntW-1:0]         count_q, count_d;
  logic [IdxW-1:0]         list_idx_q, list_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [StatW-1:0]        status_q, status_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic [LenW-1:0]         len_q, len_d;
  logic                    last_q, last_d;

  logic                    out_free, load, full, empty;
  logic [CmpW-1:0]         loc_w, cnt_w, ins_pos, del_w;
  logic                    ins_en, del_en;
  logic [IdxW-1:0]         del_idx, rd_idx;
  logic signed [DataW-1:0] rd_word;
  logic                    list_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign full      = (count_q == CntW'(Capacity));
  assign empty     = (count_q == '0);
  assign loc_w     = CmpW'(location_i);
  assign cnt_w     = CmpW'(count_q);
  assign del_w     = loc_w - CmpW'(1);
  assign del_idx   = del_w[IdxW-1:0];
  assign rd_idx    = cmd_i.list_en ? list_idx_q : del_idx;
  assign rd_word   = cells_q[rd_idx];
  assign list_last = ((CntW'(list_idx_q) + CntW'(1)) == count_q);

  assign sts_o.list_req  = (mode_i == MODE_LIST) && !empty;
  assign sts_o.out_free  = out_free;
  assign sts_o.list_last = list_last;

  always_comb begin
    count_d    = count_q;
    list_idx_d = list_idx_q;
    load       = 1'b0;
    status_d   = ST_OK;
    data_d     = '0;
    pos_d      = '0;
    len_d      = LenW'(count_q);
    last_d     = 1'b1;
    ins_en     = 1'b0;
    ins_pos    = '0;
    del_en     = 1'b0;

    if (cmd_i.op_en) begin
      load       = 1'b1;
      list_idx_d = '0;
      case (mode_e'(mode_i))
        MODE_APPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ins_en  = 1'b1;
            ins_pos = cnt_w;
          end
        end
        MODE_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ins_en  = 1'b1;
            ins_pos = '0;
          end
        end
        MODE_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else if (empty) begin
            if (loc_w > CmpW'(1)) begin
              status_d = ST_BADLOC;
            end else begin
              ins_en  = 1'b1;
              ins_pos = '0;
            end
          end else if (loc_w > cnt_w) begin
            status_d = ST_BADLOC;
          end else begin
            ins_en  = 1'b1;
            ins_pos = loc_w;
          end
        end
        MODE_DELETE: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else if (loc_w == '0 || loc_w > cnt_w) begin
            status_d = ST_BADLOC;
          end else begin
            del_en  = 1'b1;
            count_d = count_q - CntW'(1);
            data_d  = rd_word;
            pos_d   = location_i;
            len_d   = LenW'(count_d);
          end
        end
        MODE_LENGTH: begin
          status_d = empty ? ST_EMPTY : ST_OK;
        end
        MODE_LIST: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            load = 1'b0;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
      if (ins_en) begin
        count_d = count_q + CntW'(1);
        len_d   = LenW'(count_d);
      end
    end else if (cmd_i.list_en) begin
      load       = 1'b1;
      status_d   = ST_OK;
      data_d     = rd_word;
      pos_d      = PosW'(list_idx_q) + PosW'(1);
      last_d     = list_last;
      list_idx_d = list_idx_q + IdxW'(1);
    end
  end

  // parallel shift of the cell row
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      cells_d[i] = cells_q[i];
    end
    if (ins_en) begin
      for (int i = 1; i < Capacity; i++) begin
        if (CmpW'(i) > ins_pos) begin
          cells_d[i] = cells_q[i-1];
        end
      end
      cells_d[ins_pos[IdxW-1:0]] = value_i;
    end else if (del_en) begin
      for (int i = 0; i < Capacity - 1; i++) begin
        if (CmpW'(i) >= del_w) begin
          cells_d[i] = cells_q[i+1];
        end
      end
    end
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      list_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      list_idx_q  <= list_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Capacity; i++) begin
      cells_q[i] <= cells_d[i];
    end
    if (load) begin
      status_q <= status_d;
      data_q   <= data_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign position_o  = pos_q;
  assign length_o    = len_q;
  assign last_o      = last_q;

endmodule

### hw/rtl/positional_array_list_top.sv
// top level of the positional array list block
// joins the controller and the datapath
// depends on pal_pkg, pal_ctrl, pal_dp
//
// usage:
// the input channel (in_valid_i / in_stall_o) carries one operation per beat:
// mode_i, value_i, location_i. the output channel (out_valid_o / out_stall_i)
// carries result beats: status_o, data_out_o, position_o, length_o, last_o.
// append, front, insert, delete and length give one result beat in the cycle
// after the input beat; any shift of entry cells happens in that cycle, so these
// operations sustain one beat per cycle while the output is taken.
// list all gives one beat per stored entry, one per cycle while the output is
// taken, with last_o on the final one (a single empty beat when there are no
// entries); the input is stalled until the final list beat is loaded.
// the output register is the only buffer: while the receiver stalls a waiting
// result, in_stall_o is high and nothing advances.
// reset empties the list and the output register; entry cells are not cleared.
module positional_array_list_top
  import pal_pkg::*;
#(
  parameter int Capacity = CapDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ModeW-1:0]        mode_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [LocW-1:0]         location_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic signed [DataW-1:0] data_out_o,
  output logic [PosW-1:0]         position_o,
  output logic [LenW-1:0]         length_o,
  output logic                    last_o
);

  pal_cmd_t cmd;
  pal_sts_t sts;

  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pal_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .location_i  (location_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .position_o  (position_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

endmodule
